// ===== sv/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

    localparam int WAYPOINT_DEPTH_DEF = 1024;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MULT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BAND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WP_COUNT   = 3'd5;

    localparam logic [30:0] LOOKAHEAD_RST  = 31'd85197;
    localparam logic [11:0] SPEED_MULT_RST = 12'd512;
    localparam logic [13:0] STEER_LIM_RST  = 14'd1716;
    localparam logic [13:0] LOW_BAND_RST   = 14'd714;
    localparam logic [13:0] HIGH_BAND_RST  = 14'd1429;
    localparam logic [10:0] WP_COUNT_RST   = 11'd0;

    localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;

    localparam int SQRT_STEPS   = 30;
    localparam int DIV_STEPS    = 64;
    localparam int SDIV_STEPS   = 15;
    localparam int DRAIN_CYCLES = 5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NEAR, ST_DRAIN_NEAR, ST_WALK, ST_DRAIN_WALK,
        ST_QPROD, ST_QSUM, ST_QSQ, ST_ROOT_LOAD, ST_SQRT,
        ST_CROSS, ST_DIV_LOAD, ST_DIV, ST_PM_LO, ST_PM_HI, ST_PM_ADD,
        ST_SDIV_LOAD, ST_SDIV, ST_FINISH
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CAPTURE, OP_QPROD, OP_QSUM, OP_QSQ,
        OP_ROOT_LOAD, OP_SQRT_STEP, OP_CROSS, OP_DIV_LOAD, OP_DIV_STEP,
        OP_PM_LO, OP_PM_HI, OP_PM_ADD, OP_SDIV_LOAD, OP_SDIV_STEP, OP_FINISH
    } dp_op_t;

    typedef enum logic [1:0] {
        PH_NEAR, PH_WALK, PH_TGT
    } phase_t;

    typedef struct packed {
        dp_op_t op;
        logic   rd_en;
        phase_t phase;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/pps_ram.sv =====
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/pps_ctrl.sv =====
`timescale 1ns / 1ps

module pps_ctrl #(
    parameter int WAYPOINT_DEPTH = pps_pkg::WAYPOINT_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_kind,
    output logic                              s_ready,
    input  logic [$clog2(WAYPOINT_DEPTH+1)-1:0] n_used,
    input  logic [$clog2(WAYPOINT_DEPTH)-1:0] ci,
    input  pps_pkg::dp_status_t               status,
    output pps_pkg::dp_cmd_t                  cmd,
    output logic [$clog2(WAYPOINT_DEPTH)-1:0] rd_addr
);

    localparam int AW   = $clog2(WAYPOINT_DEPTH);
    localparam int CW   = $clog2(WAYPOINT_DEPTH+1);
    localparam int CNTW = (CW > 7) ? CW : 7;

    pps_pkg::ctl_state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] last_idx;

    assign last_idx = CNTW'(n_used) - CNTW'(1);
    assign rd_addr  = cnt_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pps_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd.op     = pps_pkg::OP_NONE;
        cmd.rd_en  = 1'b0;
        cmd.phase  = pps_pkg::PH_NEAR;
        unique case (state_reg)
            pps_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!s_kind) begin
                        cmd.op = pps_pkg::OP_LOAD;
                    end else begin
                        cmd.op   = pps_pkg::OP_CAPTURE;
                        cnt_next = '0;
                        state_next = (n_used == '0) ? pps_pkg::ST_QPROD : pps_pkg::ST_NEAR;
                    end
                end
            end
            pps_pkg::ST_NEAR: begin
                cmd.rd_en = 1'b1;
                cmd.phase = pps_pkg::PH_NEAR;
                if (cnt_reg == last_idx) begin
                    cnt_next   = '0;
                    state_next = pps_pkg::ST_DRAIN_NEAR;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            pps_pkg::ST_DRAIN_NEAR: begin
                // nearest index settles once the distance pipe has emptied
                if (cnt_reg == CNTW'(pps_pkg::DRAIN_CYCLES-1)) begin
                    cnt_next   = CNTW'(ci);
                    state_next = pps_pkg::ST_WALK;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            pps_pkg::ST_WALK: begin
                cmd.rd_en = 1'b1;
                cmd.phase = pps_pkg::PH_WALK;
                if (cnt_reg == last_idx) begin
                    cnt_next   = '0;
                    state_next = pps_pkg::ST_DRAIN_WALK;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            pps_pkg::ST_DRAIN_WALK: begin
                if (cnt_reg == CNTW'(pps_pkg::DRAIN_CYCLES-1)) begin
                    state_next = pps_pkg::ST_QPROD;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            pps_pkg::ST_QPROD: begin
                // target distance goes down the same pipe
                cmd.op     = pps_pkg::OP_QPROD;
                cmd.rd_en  = 1'b1;
                cmd.phase  = pps_pkg::PH_TGT;
                state_next = pps_pkg::ST_QSUM;
            end
            pps_pkg::ST_QSUM: begin
                cmd.op     = pps_pkg::OP_QSUM;
                state_next = pps_pkg::ST_QSQ;
            end
            pps_pkg::ST_QSQ: begin
                cmd.op     = pps_pkg::OP_QSQ;
                state_next = pps_pkg::ST_ROOT_LOAD;
            end
            pps_pkg::ST_ROOT_LOAD: begin
                cmd.op     = pps_pkg::OP_ROOT_LOAD;
                cnt_next   = '0;
                state_next = pps_pkg::ST_SQRT;
            end
            pps_pkg::ST_SQRT: begin
                cmd.op = pps_pkg::OP_SQRT_STEP;
                if (cnt_reg == CNTW'(pps_pkg::SQRT_STEPS-1)) begin
                    state_next = pps_pkg::ST_CROSS;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            pps_pkg::ST_CROSS: begin
                cmd.op     = pps_pkg::OP_CROSS;
                state_next = pps_pkg::ST_DIV_LOAD;
            end
            pps_pkg::ST_DIV_LOAD: begin
                cmd.op     = pps_pkg::OP_DIV_LOAD;
                cnt_next   = '0;
                state_next = pps_pkg::ST_DIV;
            end
            pps_pkg::ST_DIV: begin
                cmd.op = pps_pkg::OP_DIV_STEP;
                if (cnt_reg == CNTW'(pps_pkg::DIV_STEPS-1)) begin
                    state_next = pps_pkg::ST_PM_LO;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            pps_pkg::ST_PM_LO: begin
                cmd.op     = pps_pkg::OP_PM_LO;
                state_next = pps_pkg::ST_PM_HI;
            end
            pps_pkg::ST_PM_HI: begin
                cmd.op     = pps_pkg::OP_PM_HI;
                state_next = pps_pkg::ST_PM_ADD;
            end
            pps_pkg::ST_PM_ADD: begin
                cmd.op     = pps_pkg::OP_PM_ADD;
                state_next = pps_pkg::ST_SDIV_LOAD;
            end
            pps_pkg::ST_SDIV_LOAD: begin
                cmd.op     = pps_pkg::OP_SDIV_LOAD;
                cnt_next   = '0;
                state_next = pps_pkg::ST_SDIV;
            end
            pps_pkg::ST_SDIV: begin
                cmd.op = pps_pkg::OP_SDIV_STEP;
                if (cnt_reg == CNTW'(pps_pkg::SDIV_STEPS-1)) begin
                    state_next = pps_pkg::ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            pps_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.op     = pps_pkg::OP_FINISH;
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pps_datapath.sv =====
`timescale 1ns / 1ps

module pps_datapath #(
    parameter int WAYPOINT_DEPTH = pps_pkg::WAYPOINT_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pps_pkg::dp_cmd_t                    cmd,
    input  logic [$clog2(WAYPOINT_DEPTH)-1:0]   rd_addr,
    output pps_pkg::dp_status_t                 status,
    output logic [$clog2(WAYPOINT_DEPTH)-1:0]   ci,
    output logic [$clog2(WAYPOINT_DEPTH+1)-1:0] n_used,
    input  logic [9:0]                          s_wp_index,
    input  logic signed [31:0]                  s_pos_x,
    input  logic signed [31:0]                  s_pos_y,
    input  logic signed [15:0]                  s_quat_x,
    input  logic signed [15:0]                  s_quat_y,
    input  logic signed [15:0]                  s_quat_z,
    input  logic signed [15:0]                  s_quat_w,
    input  logic                                cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [30:0]                         cfg_wdata,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [14:0]                  m_steering,
    output logic [12:0]                         m_speed,
    output logic signed [31:0]                  m_target_x,
    output logic signed [31:0]                  m_target_y,
    output logic                                m_found,
    output logic [9:0]                          m_closest_index
);

    localparam int AW = $clog2(WAYPOINT_DEPTH);
    localparam int CW = $clog2(WAYPOINT_DEPTH+1);

    // configuration
    logic [30:0] la_reg;
    logic [11:0] mult_reg;
    logic [13:0] slim_reg, lowb_reg, highb_reg;
    logic [10:0] wpc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            la_reg    <= pps_pkg::LOOKAHEAD_RST;
            mult_reg  <= pps_pkg::SPEED_MULT_RST;
            slim_reg  <= pps_pkg::STEER_LIM_RST;
            lowb_reg  <= pps_pkg::LOW_BAND_RST;
            highb_reg <= pps_pkg::HIGH_BAND_RST;
            wpc_reg   <= pps_pkg::WP_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pps_pkg::REG_LOOKAHEAD:  la_reg    <= cfg_wdata;
                pps_pkg::REG_SPEED_MULT: mult_reg  <= cfg_wdata[11:0];
                pps_pkg::REG_STEER_LIM:  slim_reg  <= cfg_wdata[13:0];
                pps_pkg::REG_LOW_BAND:   lowb_reg  <= cfg_wdata[13:0];
                pps_pkg::REG_HIGH_BAND:  highb_reg <= cfg_wdata[13:0];
                pps_pkg::REG_WP_COUNT:   wpc_reg   <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    logic [CW+10:0] wpc_ext;
    assign wpc_ext = (CW+11)'(wpc_reg);
    assign n_used  = (32'(wpc_reg) < 32'(WAYPOINT_DEPTH)) ? wpc_ext[CW-1:0]
                                                          : CW'(WAYPOINT_DEPTH);

    // waypoint table
    logic [AW+9:0] widx_ext;
    logic          ram_we;
    logic [63:0]   rdata;

    assign widx_ext = (AW+10)'(s_wp_index);
    assign ram_we   = (cmd.op == pps_pkg::OP_LOAD) &&
                      (32'(s_wp_index) < 32'(WAYPOINT_DEPTH));

    pps_ram #(.WIDTH(64), .DEPTH(WAYPOINT_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (widx_ext[AW-1:0]),
        .wdata ({s_pos_x, s_pos_y}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // pose
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic [61:0]        l2_reg;

    // distance pipe
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    pps_pkg::phase_t   ph1_reg, ph2_reg, ph3_reg, ph4_reg;
    logic [AW-1:0]     idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [31:0] wx2_reg, wy2_reg, wx3_reg, wy3_reg, wx4_reg, wy4_reg;
    logic [31:0]       ux2_reg, uy2_reg;
    logic [63:0]       sqx3_reg, sqy3_reg;
    logic [64:0]       d4_reg;

    logic signed [31:0] wx_sel, wy_sel;
    logic signed [32:0] dxw, dyw;
    logic [32:0]        axw, ayw;

    // search state
    logic [64:0]        best_reg, prev_d_reg, dtgt_reg;
    logic [AW-1:0]      ci_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg, tx_reg, ty_reg;
    logic signed [31:0] last_x_reg, last_y_reg;
    logic               found_reg, have_prev_reg;

    logic               d_eq, d_ge, prev_le, pair_hit, walk_item;
    logic signed [32:0] sumx, sumy;

    // geometry
    logic signed [31:0] pww_reg, pxx_reg, pyy_reg, pzz_reg, pxy_reg, pwz_reg;
    logic signed [33:0] craw, sw, sraw;
    logic [33:0]        cabs, sabs;
    logic [28:0]        cm_reg;
    logic [29:0]        sm_reg;
    logic               cneg_reg, sneg_reg;
    logic [57:0]        cm2_reg;
    logic [59:0]        sm2_reg, rval_reg;
    logic [32:0]        srem_q_reg, rem2, trial;
    logic [29:0]        root_reg, rdiv_reg;
    logic               rz;
    logic signed [30:0] cs_s, ss_s;
    logic signed [32:0] dxt, dyt;
    logic signed [63:0] p1_reg, p2_reg;
    logic signed [64:0] ydiff;
    logic [64:0]        yabs;
    logic               yneg_reg;
    logic [63:0]        nsh_reg;
    logic [30:0]        drem_reg, drem2;
    logic               dge;
    logic [34:0]        yq_reg;
    logic [49:0]        plo_reg;
    logic [48:0]        phi_reg;
    logic [66:0]        num_reg, stq_rem_reg;
    logic [81:0]        dsh_reg;
    logic [14:0]        qs_reg;
    logic               sge;

    logic [13:0]        qmag, amag;
    logic [12:0]        spd;
    logic [AW+9:0]      ci_ext;

    assign ci          = ci_reg;
    assign status.out_free = !m_valid || m_ready;

    assign wx_sel = (ph1_reg == pps_pkg::PH_TGT) ? tx_reg : $signed(rdata[63:32]);
    assign wy_sel = (ph1_reg == pps_pkg::PH_TGT) ? ty_reg : $signed(rdata[31:0]);
    assign dxw    = 33'(wx_sel) - 33'(px_reg);
    assign dyw    = 33'(wy_sel) - 33'(py_reg);
    assign axw    = dxw[32] ? 33'(-dxw) : 33'(dxw);
    assign ayw    = dyw[32] ? 33'(-dyw) : 33'(dyw);

    assign walk_item = v4_reg && (ph4_reg == pps_pkg::PH_WALK) && !found_reg;
    assign d_eq      = d4_reg == 65'(l2_reg);
    assign d_ge      = d4_reg >= 65'(l2_reg);
    assign prev_le   = prev_d_reg <= 65'(l2_reg);
    // the pair ending here is checked before this entry's own exact match
    assign pair_hit  = have_prev_reg && prev_le && d_ge;
    assign sumx      = 33'(prev_x_reg) + 33'(wx4_reg);
    assign sumy      = 33'(prev_y_reg) + 33'(wy4_reg);

    assign craw = 34'(pww_reg) + 34'(pxx_reg) - 34'(pyy_reg) - 34'(pzz_reg);
    assign sw   = 34'(pxy_reg) + 34'(pwz_reg);
    assign sraw = sw <<< 1;
    assign cabs = craw[33] ? 34'(-craw) : 34'(craw);
    assign sabs = sraw[33] ? 34'(-sraw) : 34'(sraw);

    assign rem2  = {srem_q_reg[30:0], rval_reg[59:58]};
    assign trial = {1'b0, root_reg, 2'b01};

    assign rz   = root_reg == '0;
    assign cs_s = rz ? 31'sd1 : (cneg_reg ? -$signed({2'b00, cm_reg}) : $signed({2'b00, cm_reg}));
    assign ss_s = rz ? 31'sd0 : (sneg_reg ? -$signed({1'b0, sm_reg}) : $signed({1'b0, sm_reg}));
    assign dxt  = 33'(tx_reg) - 33'(px_reg);
    assign dyt  = 33'(ty_reg) - 33'(py_reg);

    assign ydiff = 65'(p1_reg) - 65'(p2_reg);
    assign yabs  = ydiff[64] ? 65'(-ydiff) : 65'(ydiff);

    assign drem2 = {drem_reg[29:0], nsh_reg[63]};
    assign dge   = drem2 >= {1'b0, rdiv_reg};

    assign sge = 82'(stq_rem_reg) >= dsh_reg;

    // a quotient of 2^14 or more saturates
    assign qmag = (dtgt_reg == '0) ? 14'd0 : (qs_reg[14] ? 14'h3FFF : qs_reg[13:0]);
    assign amag = (qmag < slim_reg) ? qmag : slim_reg;
    assign ci_ext = (AW+10)'(ci_reg);

    always_comb begin
        spd = {2'b00, mult_reg[11:1]};
        if (amag < lowb_reg) begin
            spd = {mult_reg, 1'b0};
        end
        if (amag < highb_reg && amag > lowb_reg) begin
            spd = {1'b0, mult_reg};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            m_valid       <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.op == pps_pkg::OP_CAPTURE) begin
                found_reg     <= 1'b0;
                have_prev_reg <= 1'b0;
            end else if (walk_item) begin
                have_prev_reg <= 1'b1;
                if (pair_hit || d_eq) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.op == pps_pkg::OP_FINISH) begin
                m_valid    <= 1'b1;
                last_x_reg <= tx_reg;
                last_y_reg <= ty_reg;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        ph1_reg  <= cmd.phase;
        idx1_reg <= rd_addr;
        ph2_reg  <= ph1_reg;
        idx2_reg <= idx1_reg;
        wx2_reg  <= wx_sel;
        wy2_reg  <= wy_sel;
        ux2_reg  <= axw[31:0];
        uy2_reg  <= ayw[31:0];
        ph3_reg  <= ph2_reg;
        idx3_reg <= idx2_reg;
        wx3_reg  <= wx2_reg;
        wy3_reg  <= wy2_reg;
        sqx3_reg <= 64'(ux2_reg) * 64'(ux2_reg);
        sqy3_reg <= 64'(uy2_reg) * 64'(uy2_reg);
        ph4_reg  <= ph3_reg;
        idx4_reg <= idx3_reg;
        wx4_reg  <= wx3_reg;
        wy4_reg  <= wy3_reg;
        d4_reg   <= 65'(sqx3_reg) + 65'(sqy3_reg);

        if (v4_reg && ph4_reg == pps_pkg::PH_NEAR) begin
            if (idx4_reg == '0 || d4_reg < best_reg) begin
                best_reg <= d4_reg;
                ci_reg   <= idx4_reg;
            end
        end
        if (walk_item) begin
            prev_d_reg <= d4_reg;
            prev_x_reg <= wx4_reg;
            prev_y_reg <= wy4_reg;
            if (pair_hit) begin
                tx_reg <= sumx[32:1];
                ty_reg <= sumy[32:1];
            end else if (d_eq) begin
                tx_reg <= wx4_reg;
                ty_reg <= wy4_reg;
            end
        end
        if (v4_reg && ph4_reg == pps_pkg::PH_TGT) begin
            dtgt_reg <= d4_reg;
        end

        case (cmd.op)
            pps_pkg::OP_CAPTURE: begin
                px_reg <= s_pos_x;
                py_reg <= s_pos_y;
                qx_reg <= s_quat_x;
                qy_reg <= s_quat_y;
                qz_reg <= s_quat_z;
                qw_reg <= s_quat_w;
                l2_reg <= 62'(la_reg) * 62'(la_reg);
                tx_reg <= last_x_reg;
                ty_reg <= last_y_reg;
                ci_reg <= '0;
            end
            pps_pkg::OP_QPROD: begin
                pww_reg <= 32'(qw_reg) * 32'(qw_reg);
                pxx_reg <= 32'(qx_reg) * 32'(qx_reg);
                pyy_reg <= 32'(qy_reg) * 32'(qy_reg);
                pzz_reg <= 32'(qz_reg) * 32'(qz_reg);
                pxy_reg <= 32'(qx_reg) * 32'(qy_reg);
                pwz_reg <= 32'(qw_reg) * 32'(qz_reg);
            end
            pps_pkg::OP_QSUM: begin
                cm_reg   <= cabs[31:3];
                sm_reg   <= sabs[32:3];
                cneg_reg <= craw[33];
                sneg_reg <= sraw[33];
            end
            pps_pkg::OP_QSQ: begin
                cm2_reg <= 58'(cm_reg) * 58'(cm_reg);
                sm2_reg <= 60'(sm_reg) * 60'(sm_reg);
            end
            pps_pkg::OP_ROOT_LOAD: begin
                rval_reg   <= 60'(cm2_reg) + sm2_reg;
                srem_q_reg <= '0;
                root_reg   <= '0;
            end
            pps_pkg::OP_SQRT_STEP: begin
                // two radicand bits per step, one root bit
                if (rem2 >= trial) begin
                    srem_q_reg <= rem2 - trial;
                end else begin
                    srem_q_reg <= rem2;
                end
                root_reg <= {root_reg[28:0], rem2 >= trial};
                rval_reg <= rval_reg << 2;
            end
            pps_pkg::OP_CROSS: begin
                p1_reg   <= 64'(cs_s) * 64'(dyt);
                p2_reg   <= 64'(ss_s) * 64'(dxt);
                rdiv_reg <= rz ? 30'd1 : root_reg;
            end
            pps_pkg::OP_DIV_LOAD: begin
                yneg_reg <= ydiff[64];
                nsh_reg  <= yabs[63:0];
                drem_reg <= '0;
                yq_reg   <= '0;
            end
            pps_pkg::OP_DIV_STEP: begin
                drem_reg <= dge ? drem2 - {1'b0, rdiv_reg} : drem2;
                nsh_reg  <= nsh_reg << 1;
                // lateral offset stays below 2^35
                yq_reg   <= {yq_reg[33:0], dge};
            end
            pps_pkg::OP_PM_LO: begin
                plo_reg <= 50'(yq_reg[17:0]) * 50'(pps_pkg::INV_PI_Q32);
            end
            pps_pkg::OP_PM_HI: begin
                phi_reg <= 49'(yq_reg[34:18]) * 49'(pps_pkg::INV_PI_Q32);
            end
            pps_pkg::OP_PM_ADD: begin
                num_reg <= 67'(plo_reg) + (67'(phi_reg) << 18);
            end
            pps_pkg::OP_SDIV_LOAD: begin
                stq_rem_reg <= num_reg;
                dsh_reg     <= 82'(dtgt_reg) << 17;
                qs_reg      <= '0;
            end
            pps_pkg::OP_SDIV_STEP: begin
                if (sge) begin
                    stq_rem_reg <= stq_rem_reg - dsh_reg[66:0];
                end
                dsh_reg <= dsh_reg >> 1;
                qs_reg  <= {qs_reg[13:0], sge};
            end
            pps_pkg::OP_FINISH: begin
                m_steering      <= yneg_reg ? -$signed({1'b0, amag}) : $signed({1'b0, amag});
                m_speed         <= spd;
                m_target_x      <= tx_reg;
                m_target_y      <= ty_reg;
                m_found         <= found_reg;
                m_closest_index <= ci_ext[9:0];
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/pure_pursuit_steering.sv =====
`timescale 1ns / 1ps

// channel   ports              transaction
// s_        valid/ready        load waypoint (kind 0) or vehicle pose (kind 1)
// m_        valid/ready        steering, speed, target, found, closest index
// cfg_      we/index/wdata     register write, one per cycle, no wait
//
// A load is written to the table as it is accepted. A pose holds the block
// until its result is presented: one table read per cycle for the nearest
// search over all waypoints in use and for the forward walk from the nearest
// index (both skipped with an empty table), then a 30 step square root, a
// 64 step divide and a 15 step divide for curvature.
// Synchronous active low reset; the table is not cleared.
// A finished result waits in the output register; the next pose stalls
// only at its final step while that register is full and not taken.

module pure_pursuit_steering #(
    parameter int WAYPOINT_DEPTH = pps_pkg::WAYPOINT_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [9:0]                    s_wp_index,
    input  logic signed [31:0]            s_pos_x,
    input  logic signed [31:0]            s_pos_y,
    input  logic signed [15:0]            s_quat_x,
    input  logic signed [15:0]            s_quat_y,
    input  logic signed [15:0]            s_quat_z,
    input  logic signed [15:0]            s_quat_w,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [14:0]            m_steering,
    output logic [12:0]                   m_speed,
    output logic signed [31:0]            m_target_x,
    output logic signed [31:0]            m_target_y,
    output logic                          m_found,
    output logic [9:0]                    m_closest_index,
    input  logic                          cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]                   cfg_wdata
);

    pps_pkg::dp_cmd_t                    cmd;
    pps_pkg::dp_status_t                 status;
    logic [$clog2(WAYPOINT_DEPTH)-1:0]   rd_addr, ci;
    logic [$clog2(WAYPOINT_DEPTH+1)-1:0] n_used;

    pps_ctrl #(.WAYPOINT_DEPTH(WAYPOINT_DEPTH)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .n_used  (n_used),
        .ci      (ci),
        .status  (status),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    pps_datapath #(.WAYPOINT_DEPTH(WAYPOINT_DEPTH)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .status          (status),
        .ci              (ci),
        .n_used          (n_used),
        .s_wp_index      (s_wp_index),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_quat_x        (s_quat_x),
        .s_quat_y        (s_quat_y),
        .s_quat_z        (s_quat_z),
        .s_quat_w        (s_quat_w),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_steering      (m_steering),
        .m_speed         (m_speed),
        .m_target_x      (m_target_x),
        .m_target_y      (m_target_y),
        .m_found         (m_found),
        .m_closest_index (m_closest_index)
    );

    // a load never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_kind && !m_valid) |=> !m_valid)
        else $error("result after load transaction");

    // a pose keeps the block busy
    a_pose_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind) |=> !s_ready)
        else $error("input ready right after pose transaction");

    // a result is only produced as the block returns to idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result while still busy");

endmodule
